@@ design/interleaved_sum_frame_checker_defines.svh @@
`ifndef INTERLEAVED_SUM_FRAME_CHECKER_DEFINES_SVH
`define INTERLEAVED_SUM_FRAME_CHECKER_DEFINES_SVH

// same-cycle check, sampled on the rising clock, off during reset
`define ISFC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle check, sampled on the rising clock, off during reset
`define ISFC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/isfc_pkg.sv @@
`timescale 1ns / 1ps

package isfc_pkg;

   // frame layout
   localparam int unsigned POS_W = 3;
   typedef logic [POS_W-1:0] pos_type;
   typedef logic [7:0]       byte_type;

   localparam pos_type HEADER_LEN    = 3'd3;
   localparam pos_type FRAME_MIN_LEN = 3'd6;
   // byte leaving the delay line is payload from this count on
   localparam pos_type PAYLOAD_START = HEADER_LEN + 3'd2;
   // a final byte seen below this count ends a short frame
   localparam pos_type SHORT_LIMIT   = FRAME_MIN_LEN - 3'd1;

   // result status codes
   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_MISMATCH = 2'd1,
      STATUS_SHORT    = 2'd2
   } status_type;

endpackage

@@ design/interleaved_sum_frame_checker.sv @@
`timescale 1ns / 1ps

// Checks frames that arrive one byte per item, the last byte flagged by
// req_last_byte. Three header bytes are skipped, payload bytes alternate
// between an even and an odd 8-bit wrapping sum, and the final two bytes of
// the frame are compared against those sums. One result item (ok, mismatch,
// or short when the frame has fewer than six bytes) is produced per frame,
// registered, in the cycle after the final byte is taken. Save for the stall
// below, a byte is accepted in every cycle: the whole update is one add and
// compare between the state and result registers. While a result waits,
// non-final bytes are still taken; a final byte waits for the result to leave.
module interleaved_sum_frame_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_byte_value,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_status,
   output logic [7:0] rsp_even_sum,
   output logic [7:0] rsp_odd_sum
);

   // frame state
   isfc_pkg::pos_type    pos_ff, pos_in;
   logic                 parity_ff, parity_in;
   isfc_pkg::byte_type   sum_even_ff, sum_even_in;
   isfc_pkg::byte_type   sum_odd_ff, sum_odd_in;
   isfc_pkg::byte_type   delay_older_ff, delay_older_in;
   isfc_pkg::byte_type   delay_newer_ff, delay_newer_in;

   // result register
   logic                   rsp_valid_ff, rsp_valid_in;
   isfc_pkg::status_type   status_ff, status_in;
   isfc_pkg::byte_type     even_out_ff, even_out_in;
   isfc_pkg::byte_type     odd_out_ff, odd_out_in;

   logic                 accept;
   logic                 accept_last;
   logic                 add_payload;
   isfc_pkg::byte_type   sum_even_upd;
   isfc_pkg::byte_type   sum_odd_upd;

   // handshake
   assign req_ready   = !rsp_valid_ff || rsp_ready || !req_last_byte;
   assign accept      = req_valid && req_ready;
   assign accept_last = accept && req_last_byte;

   // running sums with the byte leaving the delay line
   always_comb begin
      add_payload  = (pos_ff >= isfc_pkg::PAYLOAD_START);
      sum_even_upd = sum_even_ff;
      sum_odd_upd  = sum_odd_ff;
      if (add_payload && !parity_ff) begin
         sum_even_upd = sum_even_ff + delay_older_ff;
      end
      if (add_payload && parity_ff) begin
         sum_odd_upd = sum_odd_ff + delay_older_ff;
      end
   end

   // state update
   always_comb begin
      pos_in         = pos_ff;
      parity_in      = parity_ff;
      sum_even_in    = sum_even_ff;
      sum_odd_in     = sum_odd_ff;
      delay_older_in = delay_older_ff;
      delay_newer_in = delay_newer_ff;
      if (accept_last) begin
         pos_in         = '0;
         parity_in      = 1'b0;
         sum_even_in    = '0;
         sum_odd_in     = '0;
         delay_older_in = '0;
         delay_newer_in = '0;
      end else if (accept) begin
         parity_in      = parity_ff ^ add_payload;
         sum_even_in    = sum_even_upd;
         sum_odd_in     = sum_odd_upd;
         delay_older_in = delay_newer_ff;
         delay_newer_in = req_byte_value;
         if (pos_ff < isfc_pkg::FRAME_MIN_LEN) begin
            pos_in = pos_ff + 3'd1;
         end
      end
   end

   // result item on the final byte
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      status_in    = status_ff;
      even_out_in  = even_out_ff;
      odd_out_in   = odd_out_ff;
      if (accept_last) begin
         rsp_valid_in = 1'b1;
         even_out_in  = sum_even_upd;
         odd_out_in   = sum_odd_upd;
         if (pos_ff < isfc_pkg::SHORT_LIMIT) begin
            status_in = isfc_pkg::STATUS_SHORT;
         end else if (sum_even_upd == delay_newer_ff && sum_odd_upd == req_byte_value) begin
            status_in = isfc_pkg::STATUS_OK;
         end else begin
            status_in = isfc_pkg::STATUS_MISMATCH;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff         <= '0;
         parity_ff      <= 1'b0;
         sum_even_ff    <= '0;
         sum_odd_ff     <= '0;
         delay_older_ff <= '0;
         delay_newer_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         pos_ff         <= pos_in;
         parity_ff      <= parity_in;
         sum_even_ff    <= sum_even_in;
         sum_odd_ff     <= sum_odd_in;
         delay_older_ff <= delay_older_in;
         delay_newer_ff <= delay_newer_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      status_ff   <= status_in;
      even_out_ff <= even_out_in;
      odd_out_ff  <= odd_out_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = status_ff;
   assign rsp_even_sum = even_out_ff;
   assign rsp_odd_sum  = odd_out_ff;

`include "interleaved_sum_frame_checker_defines.svh"

   // no payload byte is summed before the payload start
   `ISFC_ASSERT_NOW(a_no_sum_early, pos_ff < isfc_pkg::PAYLOAD_START, !parity_ff && sum_even_ff == 8'd0 && sum_odd_ff == 8'd0, "sums moved before payload start")

   // short frames report zero sums
   `ISFC_ASSERT_NOW(a_short_zero, rsp_valid_ff && status_ff == isfc_pkg::STATUS_SHORT, even_out_ff == 8'd0 && odd_out_ff == 8'd0, "short frame with nonzero sums")

   // a final byte clears the frame state and raises a result
   `ISFC_ASSERT_NEXT(a_last_clears, accept_last, rsp_valid_ff && pos_ff == 3'd0 && delay_newer_ff == 8'd0, "final byte did not close frame")

   // the position count saturates
   `ISFC_ASSERT_NOW(a_pos_range, 1'b1, pos_ff <= isfc_pkg::FRAME_MIN_LEN, "position count out of range")

endmodule
